[rtl/core/sie_pkg.sv]
`default_nettype none
package sie_pkg;

  // sizes
  localparam int NUM_VARS    = 16;
  localparam int VAR_IDX_W   = 4;
  localparam int STACK_DEPTH = 16;
  localparam int STACK_IDX_W = 4;
  localparam int STACK_CNT_W = 5;
  localparam int LINE_W      = 10;
  localparam int JLINE_W     = 11;
  localparam int DATA_W      = 32;

  localparam logic [DATA_W-1:0] READ_VALUE_RESET = 32'd987;

  // opcodes
  typedef enum logic [3:0] {
    OP_SET    = 4'd0,
    OP_GPIO   = 4'd1,
    OP_DELAY  = 4'd2,
    OP_GOTO   = 4'd3,
    OP_LABEL  = 4'd4,
    OP_IF     = 4'd5,
    OP_READ   = 4'd6,
    OP_PRINT  = 4'd7,
    OP_ADD    = 4'd8,
    OP_SUB    = 4'd9,
    OP_CALL   = 4'd10,
    OP_RETURN = 4'd11
  } op_t;

  // status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNDEF_LABEL  = 3'd1,
    ST_EMPTY_RETURN = 3'd2,
    ST_UNWRITTEN    = 3'd3,
    ST_BAD_COMPARE  = 3'd4,
    ST_OVERFLOW     = 3'd5
  } status_t;

  // compare codes
  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_NE = 3'd1,
    CMP_GT = 3'd2,
    CMP_LT = 3'd3,
    CMP_GE = 3'd4,
    CMP_LE = 3'd5
  } cmp_t;

  // decoded instruction word held in the execute stage
  typedef struct packed {
    logic [3:0]           op;
    logic [LINE_W-1:0]    line_number;
    logic [VAR_IDX_W-1:0] dest_reg;
    logic                 a_is_reg;
    logic [VAR_IDX_W-1:0] a_reg;
    logic [DATA_W-1:0]    a_imm;
    logic                 b_is_reg;
    logic [VAR_IDX_W-1:0] b_reg;
    logic [DATA_W-1:0]    b_imm;
    logic [2:0]           compare_code;
    logic [LINE_W-1:0]    target_line;
    logic                 target_defined;
  } item_t;

  // result word
  typedef struct packed {
    status_t             status;
    logic                jump;
    logic [JLINE_W-1:0]  jump_line;
    logic                is_call;
    logic                is_return;
    logic                wrote_reg;
    logic [DATA_W-1:0]   write_value;
  } result_t;

  // return stack control
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [JLINE_W-1:0] push_line;
  } stack_ctl_t;

  // return stack status
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [JLINE_W-1:0] top;
  } stack_sts_t;

endpackage
`default_nettype wire

[rtl/core/sie_var_file.sv]
`default_nettype none
module sie_var_file (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               rd_en,
  input  wire logic [sie_pkg::VAR_IDX_W-1:0]      rd_a_idx,
  input  wire logic [sie_pkg::VAR_IDX_W-1:0]      rd_b_idx,
  output logic      [sie_pkg::DATA_W-1:0]         rd_a_data_r,
  output logic      [sie_pkg::DATA_W-1:0]         rd_b_data_r,
  input  wire logic                               wr_en,
  input  wire logic [sie_pkg::VAR_IDX_W-1:0]      wr_idx,
  input  wire logic [sie_pkg::DATA_W-1:0]         wr_data,
  output logic      [sie_pkg::NUM_VARS-1:0]       written_r
);

  logic [sie_pkg::DATA_W-1:0] mem [sie_pkg::NUM_VARS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // two registered read ports, forwarding the write of the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_data_r <= (wr_en && (wr_idx == rd_a_idx)) ? wr_data : mem[rd_a_idx];
      rd_b_data_r <= (wr_en && (wr_idx == rd_b_idx)) ? wr_data : mem[rd_b_idx];
    end
  end

  // written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_idx] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sie_ret_stack.sv]
`default_nettype none
module sie_ret_stack (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sie_pkg::stack_ctl_t ctl,
  output sie_pkg::stack_sts_t      sts,
  output logic [sie_pkg::STACK_CNT_W-1:0] count_r
);

  logic [sie_pkg::JLINE_W-1:0]     entry_r [sie_pkg::STACK_DEPTH];
  logic [sie_pkg::STACK_CNT_W-1:0] count_nxt;
  logic [sie_pkg::STACK_CNT_W-1:0] top_ptr;

  // top of stack sits one below the fill count
  assign top_ptr   = count_r - sie_pkg::STACK_CNT_W'(1);
  assign sts.full  = (count_r == sie_pkg::STACK_CNT_W'(sie_pkg::STACK_DEPTH));
  assign sts.empty = (count_r == '0);
  assign sts.top   = entry_r[top_ptr[sie_pkg::STACK_IDX_W-1:0]];

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + sie_pkg::STACK_CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = top_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry_r[count_r[sie_pkg::STACK_IDX_W-1:0]] <= ctl.push_line;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sie_exec.sv]
`default_nettype none
module sie_exec (
  input  wire sie_pkg::item_t                    item,
  input  wire logic [sie_pkg::DATA_W-1:0]        a_rd_data,
  input  wire logic [sie_pkg::DATA_W-1:0]        b_rd_data,
  input  wire logic [sie_pkg::NUM_VARS-1:0]      written,
  input  wire logic [sie_pkg::DATA_W-1:0]        read_value,
  input  wire sie_pkg::stack_sts_t               stk_sts,
  output sie_pkg::result_t                       res,
  output sie_pkg::stack_ctl_t                    stk_ctl
);

  logic                        a_ok;
  logic                        b_ok;
  logic [sie_pkg::DATA_W-1:0]  a_val;
  logic [sie_pkg::DATA_W-1:0]  b_val;
  logic                        a_eq_b;
  logic                        a_lt_b;
  logic                        b_lt_a;
  logic                        cmp_true;
  logic                        cmp_bad;
  logic                        wr_req;
  logic [sie_pkg::DATA_W-1:0]  wval;

  // operand select and written check
  assign a_ok  = !item.a_is_reg || written[item.a_reg];
  assign b_ok  = !item.b_is_reg || written[item.b_reg];
  assign a_val = item.a_is_reg ? a_rd_data : item.a_imm;
  assign b_val = item.b_is_reg ? b_rd_data : item.b_imm;

  // signed compares
  assign a_eq_b = (a_val == b_val);
  assign a_lt_b = ($signed(a_val) < $signed(b_val));
  assign b_lt_a = ($signed(b_val) < $signed(a_val));

  always_comb begin
    cmp_true = 1'b0;
    cmp_bad  = 1'b0;
    case (sie_pkg::cmp_t'(item.compare_code))
      sie_pkg::CMP_EQ: cmp_true = a_eq_b;
      sie_pkg::CMP_NE: cmp_true = !a_eq_b;
      sie_pkg::CMP_GT: cmp_true = b_lt_a;
      sie_pkg::CMP_LT: cmp_true = a_lt_b;
      sie_pkg::CMP_GE: cmp_true = !a_lt_b;
      sie_pkg::CMP_LE: cmp_true = !b_lt_a;
      default:         cmp_bad  = 1'b1;
    endcase
  end

  // instruction decode and result
  always_comb begin
    res     = '0;
    stk_ctl = '0;
    wr_req  = 1'b0;
    wval    = '0;
    stk_ctl.push_line = {1'b0, item.line_number} + sie_pkg::JLINE_W'(1);
    case (sie_pkg::op_t'(item.op))
      sie_pkg::OP_SET: begin
        wr_req = 1'b1;
        wval   = item.a_imm;
      end
      sie_pkg::OP_GOTO: begin
        if (item.target_defined) begin
          res.jump      = 1'b1;
          res.jump_line = {1'b0, item.target_line};
        end else begin
          res.status = sie_pkg::ST_UNDEF_LABEL;
        end
      end
      sie_pkg::OP_IF: begin
        if (!(a_ok && b_ok)) begin
          res.status = sie_pkg::ST_UNWRITTEN;
        end else if (cmp_bad) begin
          res.status = sie_pkg::ST_BAD_COMPARE;
        end else if (cmp_true) begin
          if (item.target_defined) begin
            res.jump      = 1'b1;
            res.jump_line = {1'b0, item.target_line};
          end else begin
            res.status = sie_pkg::ST_UNDEF_LABEL;
          end
        end
      end
      sie_pkg::OP_READ: begin
        wr_req = 1'b1;
        wval   = read_value;
      end
      sie_pkg::OP_ADD, sie_pkg::OP_SUB: begin
        if (!(a_ok && b_ok)) begin
          res.status = sie_pkg::ST_UNWRITTEN;
        end else begin
          wr_req = 1'b1;
          wval   = (item.op == sie_pkg::OP_ADD) ? (a_val + b_val) : (a_val - b_val);
        end
      end
      sie_pkg::OP_CALL: begin
        if (!item.target_defined) begin
          res.status = sie_pkg::ST_UNDEF_LABEL;
        end else if (stk_sts.full) begin
          res.status = sie_pkg::ST_OVERFLOW;
        end else begin
          stk_ctl.push  = 1'b1;
          res.jump      = 1'b1;
          res.is_call   = 1'b1;
          res.jump_line = {1'b0, item.target_line};
        end
      end
      sie_pkg::OP_RETURN: begin
        if (stk_sts.empty) begin
          res.status = sie_pkg::ST_EMPTY_RETURN;
        end else begin
          stk_ctl.pop   = 1'b1;
          res.jump      = 1'b1;
          res.is_return = 1'b1;
          res.jump_line = stk_sts.top;
        end
      end
      default: begin
        // gpio, delay, label, print and unused codes do nothing
      end
    endcase
    res.wrote_reg   = wr_req;
    res.write_value = wr_req ? wval : '0;
  end

endmodule
`default_nettype wire

[rtl/core/script_instruction_execute_core.sv]
// Script instruction execute core.
// Input channel (in_*): one pre-decoded instruction word per accepted
// in_valid / in_stall handshake. Result channel (out_*): one status word
// per instruction, in order, under the same valid / stall handshake.
// cfg_we / cfg_wdata load the read value used by READ; write it only
// while no instruction is in flight.
// An accepted word loads the instruction register; its result then loads
// the result register, which drives out_*.
// Throughput: one instruction per cycle while out_stall is low. The
// variable file is read at the accept edge and written, together with the
// return stack, when the result register loads, with forwarding into the
// read port, so back-to-back dependent instructions run without a bubble.
// Reset (rst_n low, synchronous): both stages empty, all variables
// unwritten, return stack empty, read value back to 987.
// When out_stall holds a presented result, the instruction register keeps
// its word until the result register frees up; in_stall rises only while
// both stages are full and the result is stalled.
`default_nettype none
module script_instruction_execute_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic signed [31:0]  cfg_wdata,
  // instruction channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [3:0]          in_op,
  input  wire logic [9:0]          in_line_number,
  input  wire logic [3:0]          in_dest_reg,
  input  wire logic                in_a_is_reg,
  input  wire logic [3:0]          in_a_reg,
  input  wire logic signed [31:0]  in_a_imm,
  input  wire logic                in_b_is_reg,
  input  wire logic [3:0]          in_b_reg,
  input  wire logic signed [31:0]  in_b_imm,
  input  wire logic [2:0]          in_compare_code,
  input  wire logic [9:0]          in_target_line,
  input  wire logic                in_target_defined,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_status,
  output logic                     out_jump,
  output logic [10:0]              out_jump_line,
  output logic                     out_is_call,
  output logic                     out_is_return,
  output logic                     out_wrote_reg,
  output logic signed [31:0]       out_write_value
);

  logic                                in_acc;
  logic                                s1_adv;
  logic                                s1_valid_r;
  sie_pkg::item_t                      s1_item_r;
  logic                                out_valid_r;
  sie_pkg::result_t                    out_res_r;
  logic [sie_pkg::DATA_W-1:0]          read_value_r;
  logic [sie_pkg::DATA_W-1:0]          a_rd_data_r;
  logic [sie_pkg::DATA_W-1:0]          b_rd_data_r;
  logic [sie_pkg::NUM_VARS-1:0]        written_r;
  logic [sie_pkg::STACK_CNT_W-1:0]     stk_count_r;
  sie_pkg::result_t                    res;
  sie_pkg::stack_ctl_t                 exec_stk_ctl;
  sie_pkg::stack_ctl_t                 stk_ctl;
  sie_pkg::stack_sts_t                 stk_sts;
  logic                                var_wr_en;

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // read value register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_value_r <= sie_pkg::READ_VALUE_RESET;
    end else if (cfg_we) begin
      read_value_r <= cfg_wdata;
    end
  end

  // instruction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op             <= in_op;
      s1_item_r.line_number    <= in_line_number;
      s1_item_r.dest_reg       <= in_dest_reg;
      s1_item_r.a_is_reg       <= in_a_is_reg;
      s1_item_r.a_reg          <= in_a_reg;
      s1_item_r.a_imm          <= in_a_imm;
      s1_item_r.b_is_reg       <= in_b_is_reg;
      s1_item_r.b_reg          <= in_b_reg;
      s1_item_r.b_imm          <= in_b_imm;
      s1_item_r.compare_code   <= in_compare_code;
      s1_item_r.target_line    <= in_target_line;
      s1_item_r.target_defined <= in_target_defined;
    end
  end

  // variable file, read at accept, written when the result is loaded
  assign var_wr_en = s1_adv && res.wrote_reg;

  sie_var_file u_var_file (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_acc),
    .rd_a_idx    (in_a_reg),
    .rd_b_idx    (in_b_reg),
    .rd_a_data_r (a_rd_data_r),
    .rd_b_data_r (b_rd_data_r),
    .wr_en       (var_wr_en),
    .wr_idx      (s1_item_r.dest_reg),
    .wr_data     (res.write_value),
    .written_r   (written_r)
  );

  // return stack, updated only when the instruction retires
  always_comb begin
    stk_ctl      = exec_stk_ctl;
    stk_ctl.push = exec_stk_ctl.push && s1_adv;
    stk_ctl.pop  = exec_stk_ctl.pop && s1_adv;
  end

  sie_ret_stack u_ret_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (stk_ctl),
    .sts     (stk_sts),
    .count_r (stk_count_r)
  );

  // execute
  sie_exec u_exec (
    .item       (s1_item_r),
    .a_rd_data  (a_rd_data_r),
    .b_rd_data  (b_rd_data_r),
    .written    (written_r),
    .read_value (read_value_r),
    .stk_sts    (stk_sts),
    .res        (res),
    .stk_ctl    (exec_stk_ctl)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_jump        = out_res_r.jump;
  assign out_jump_line   = out_res_r.jump_line;
  assign out_is_call     = out_res_r.is_call;
  assign out_is_return   = out_res_r.is_return;
  assign out_wrote_reg   = out_res_r.wrote_reg;
  assign out_write_value = out_res_r.write_value;

  // a retired push grows the stack by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctl.push |=> (stk_count_r == $past(stk_count_r) + sie_pkg::STACK_CNT_W'(1)))
    else $error("return stack count did not grow on push");

  // a retired write marks its destination written
  a_write_flag: assert property (@(posedge clk) disable iff (!rst_n)
    var_wr_en |=> written_r[$past(s1_item_r.dest_reg)])
    else $error("written flag not set after variable write");

  // an instruction that fails leaves the return stack alone
  a_error_no_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (res.status != sie_pkg::ST_OK)) |=> $stable(stk_count_r))
    else $error("return stack changed on a failed instruction");

  // a loaded result never reports a write together with an error
  a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != sie_pkg::ST_OK)) |-> !out_res_r.wrote_reg
      && !out_res_r.jump)
    else $error("failed instruction reports a write or jump");

endmodule
`default_nettype wire
